>>> design/aat_pkg.sv
package aat_pkg;

    localparam int CoordW = 32;
    localparam int CoefW  = 20;
    localparam int FracW  = 16;
    localparam int RowW   = 3 * CoefW;
    localparam int ProdW  = CoordW + CoefW;
    localparam int SumW   = ProdW + 3;
    localparam int ShW    = SumW - FracW;
    localparam int IdxW   = 3;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [CoefW-1:0]  coef_t;
    typedef logic signed [ProdW-1:0]  prod_t;
    typedef logic signed [SumW-1:0]   sum_t;
    typedef logic        [RowW-1:0]   row_t;

    typedef coef_t [2:0]  coef_row_t;
    typedef coord_t [2:0] coord_vec_t;
    typedef prod_t [2:0]  prod_row_t;
    typedef sum_t [2:0]   sum_vec_t;

    typedef enum logic [IdxW-1:0] {
        REG_ROW_ONE   = 3'd0,
        REG_ROW_TWO   = 3'd1,
        REG_ROW_THREE = 3'd2,
        REG_SHIFT_X   = 3'd3,
        REG_SHIFT_Y   = 3'd4,
        REG_SHIFT_Z   = 3'd5
    } reg_idx_t;

    localparam row_t RowOneRst   = row_t'(60'd65536);
    localparam row_t RowTwoRst   = row_t'(60'd68719476736);
    localparam row_t RowThreeRst = row_t'(60'd72057594037927936);

    // m[i][j]: source axis i feeds result axis j
    typedef struct packed {
        coef_row_t [2:0] m;
        coord_vec_t      shift;
    } cfg_t;

    typedef struct packed {
        logic signed [CoordW-1:0] box_min_x;
        logic signed [CoordW-1:0] box_min_y;
        logic signed [CoordW-1:0] box_min_z;
        logic signed [CoordW-1:0] box_max_x;
        logic signed [CoordW-1:0] box_max_y;
        logic signed [CoordW-1:0] box_max_z;
    } box_in_t;

    typedef struct packed {
        logic signed [CoordW-1:0] out_min_x;
        logic signed [CoordW-1:0] out_min_y;
        logic signed [CoordW-1:0] out_min_z;
        logic signed [CoordW-1:0] out_max_x;
        logic signed [CoordW-1:0] out_max_y;
        logic signed [CoordW-1:0] out_max_z;
        logic                     saturated;
    } box_out_t;

endpackage

>>> design/aat_cfg.sv
module aat_cfg
    import aat_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [IdxW-1:0]        cfg_index,
    input  logic [RowW-1:0]        cfg_data,
    output cfg_t                   cfg
);

    row_t   row_one_reg, row_one_next;
    row_t   row_two_reg, row_two_next;
    row_t   row_three_reg, row_three_next;
    coord_t shift_x_reg, shift_x_next;
    coord_t shift_y_reg, shift_y_next;
    coord_t shift_z_reg, shift_z_next;

    always_comb
    begin
        row_one_next   = row_one_reg;
        row_two_next   = row_two_reg;
        row_three_next = row_three_reg;
        shift_x_next   = shift_x_reg;
        shift_y_next   = shift_y_reg;
        shift_z_next   = shift_z_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_ONE:   row_one_next   = cfg_data;
                REG_ROW_TWO:   row_two_next   = cfg_data;
                REG_ROW_THREE: row_three_next = cfg_data;
                REG_SHIFT_X:   shift_x_next   = coord_t'(cfg_data[CoordW-1:0]);
                REG_SHIFT_Y:   shift_y_next   = coord_t'(cfg_data[CoordW-1:0]);
                REG_SHIFT_Z:   shift_z_next   = coord_t'(cfg_data[CoordW-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_one_reg   <= RowOneRst;
            row_two_reg   <= RowTwoRst;
            row_three_reg <= RowThreeRst;
            shift_x_reg   <= '0;
            shift_y_reg   <= '0;
            shift_z_reg   <= '0;
        end
        else
        begin
            row_one_reg   <= row_one_next;
            row_two_reg   <= row_two_next;
            row_three_reg <= row_three_next;
            shift_x_reg   <= shift_x_next;
            shift_y_reg   <= shift_y_next;
            shift_z_reg   <= shift_z_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cfg.m[0][k] = coef_t'(row_one_reg[k*CoefW +: CoefW]);
            cfg.m[1][k] = coef_t'(row_two_reg[k*CoefW +: CoefW]);
            cfg.m[2][k] = coef_t'(row_three_reg[k*CoefW +: CoefW]);
        end
        cfg.shift[0] = shift_x_reg;
        cfg.shift[1] = shift_y_reg;
        cfg.shift[2] = shift_z_reg;
    end

endmodule

>>> design/aat_mul.sv
module aat_mul
    import aat_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  box_in_t         in_data,
    input  cfg_t            cfg,
    output logic            prod_valid,
    output prod_row_t [2:0] lo_prod,
    output prod_row_t [2:0] hi_prod
);

    coord_vec_t       src_min, src_max;
    coord_vec_t [2:0] lo_op_next, hi_op_next;
    coord_vec_t [2:0] lo_op_reg, hi_op_reg;
    prod_row_t  [2:0] lo_prod_next, hi_prod_next;
    prod_row_t  [2:0] lo_prod_reg, hi_prod_reg;
    logic             op_valid_reg, prod_valid_reg;

    assign src_min[0] = in_data.box_min_x;
    assign src_min[1] = in_data.box_min_y;
    assign src_min[2] = in_data.box_min_z;
    assign src_max[0] = in_data.box_max_x;
    assign src_max[1] = in_data.box_max_y;
    assign src_max[2] = in_data.box_max_z;

    // positive coefficient: min pairs with min; zero and negative swap corners
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!cfg.m[i][j][CoefW-1] && (cfg.m[i][j] != '0))
                begin
                    lo_op_next[i][j] = src_min[i];
                    hi_op_next[i][j] = src_max[i];
                end
                else
                begin
                    lo_op_next[i][j] = src_max[i];
                    hi_op_next[i][j] = src_min[i];
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lo_prod_next[i][j] = $signed(cfg.m[i][j]) * $signed(lo_op_reg[i][j]);
                hi_prod_next[i][j] = $signed(cfg.m[i][j]) * $signed(hi_op_reg[i][j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            op_valid_reg   <= in_valid;
            prod_valid_reg <= op_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_op_reg   <= lo_op_next;
            hi_op_reg   <= hi_op_next;
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign lo_prod    = lo_prod_reg;
    assign hi_prod    = hi_prod_reg;

endmodule

>>> design/aat_acc.sv
module aat_acc
    import aat_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            prod_valid,
    input  prod_row_t [2:0] lo_prod,
    input  prod_row_t [2:0] hi_prod,
    input  cfg_t            cfg,
    output logic            out_valid,
    output box_out_t        out_data
);

    localparam int PadW = SumW - CoordW - FracW;

    sum_vec_t   lo_part_next, hi_part_next, lo_part_reg, hi_part_reg;
    prod_row_t  lo_last_reg, hi_last_reg;
    sum_vec_t   lo_sum_next, hi_sum_next, lo_sum_reg, hi_sum_reg;
    coord_vec_t lo_res, hi_res;
    logic [5:0] clamp;
    box_out_t   out_next, out_reg;
    logic       part_valid_reg, sum_valid_reg, out_valid_reg;

    // translation aligned to the product scale, then the first two terms
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            lo_part_next[j] = sum_t'({{PadW{cfg.shift[j][CoordW-1]}}, cfg.shift[j],
                                      {FracW{1'b0}}})
                              + sum_t'(lo_prod[0][j]) + sum_t'(lo_prod[1][j]);
            hi_part_next[j] = sum_t'({{PadW{cfg.shift[j][CoordW-1]}}, cfg.shift[j],
                                      {FracW{1'b0}}})
                              + sum_t'(hi_prod[0][j]) + sum_t'(hi_prod[1][j]);
            lo_sum_next[j]  = lo_part_reg[j] + sum_t'(lo_last_reg[j]);
            hi_sum_next[j]  = hi_part_reg[j] + sum_t'(hi_last_reg[j]);
        end
    end

    // floor shift, clamp when the top bits disagree
    always_comb
    begin
        logic signed [ShW-1:0] t;
        for (int j = 0; j < 3; j++)
        begin
            t = lo_sum_reg[j][SumW-1:FracW];
            clamp[j] = (t[ShW-1:CoordW-1] != {(ShW-CoordW+1){t[ShW-1]}});
            if (clamp[j])
                lo_res[j] = {t[ShW-1], {(CoordW-1){~t[ShW-1]}}};
            else
                lo_res[j] = t[CoordW-1:0];
            t = hi_sum_reg[j][SumW-1:FracW];
            clamp[j+3] = (t[ShW-1:CoordW-1] != {(ShW-CoordW+1){t[ShW-1]}});
            if (clamp[j+3])
                hi_res[j] = {t[ShW-1], {(CoordW-1){~t[ShW-1]}}};
            else
                hi_res[j] = t[CoordW-1:0];
        end
        out_next.out_min_x = lo_res[0];
        out_next.out_min_y = lo_res[1];
        out_next.out_min_z = lo_res[2];
        out_next.out_max_x = hi_res[0];
        out_next.out_max_y = hi_res[1];
        out_next.out_max_z = hi_res[2];
        out_next.saturated = |clamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            part_valid_reg <= prod_valid;
            sum_valid_reg  <= part_valid_reg;
            out_valid_reg  <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lo_last_reg[j] <= lo_prod[2][j];
                hi_last_reg[j] <= hi_prod[2][j];
            end
            lo_part_reg <= lo_part_next;
            hi_part_reg <= hi_part_next;
            lo_sum_reg  <= lo_sum_next;
            hi_sum_reg  <= hi_sum_next;
            out_reg     <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> design/affine_aabb_transform_core.sv
// Transformed axis-aligned box: each beat carries a box as min/max corners in
// signed Q16.16; the block applies the 3x3 Q4.16 matrix (row-vector form, row i
// scales source axis i) plus translation and returns the tight enclosing box,
// floored to Q16.16 and clamped to 32 bits, with saturated set if any corner
// coordinate clamped. One beat is taken every cycle unless the pipeline is held;
// each result passes the operand select, multiply, two add and floor/clamp stages.
// The pipeline advances as a whole and holds while a waiting result is stalled.
// Config registers: 0..2 matrix rows, 3..5 translation x/y/z; write them only
// while the pipeline is empty.
module affine_aabb_transform_core
    import aat_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [IdxW-1:0] cfg_index,
    input  logic [RowW-1:0] cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  box_in_t         in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output box_out_t        out_data
);

    cfg_t            cfg;
    logic            adv;
    logic            prod_valid;
    prod_row_t [2:0] lo_prod, hi_prod;

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    aat_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    aat_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .lo_prod    (lo_prod),
        .hi_prod    (hi_prod)
    );

    aat_acc u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .prod_valid (prod_valid),
        .lo_prod    (lo_prod),
        .hi_prod    (hi_prod),
        .cfg        (cfg),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

endmodule

>>> tb/tb_top.sv
module tb_top;
    import aat_pkg::*;

    localparam logic [IdxW-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [IdxW-1:0] IDX_SPARE_B = 3'd7;
    localparam coord_t CMAX = 32'sh7FFF_FFFF;
    localparam coord_t CMIN = 32'sh8000_0000;
    localparam coef_t  KMAX = 20'sh7FFFF;
    localparam coef_t  KMIN = 20'sh80000;
    localparam coef_t  KONE = 20'sh10000;
    localparam int     RAND_PHASES = 12;
    localparam int     PHASE_BOXES = 146;
    localparam int     HOLD_CYCLES = 300;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_we = 1'b0;
    logic [IdxW-1:0] cfg_index = '0;
    row_t     cfg_data = '0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    box_in_t  in_data = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    box_out_t out_data;

    affine_aabb_transform_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the matrix and translation registers
    row_t   mat_row [3];
    coord_t offset  [3];

    box_in_t  box_q [$];
    box_out_t want_q [$];

    int tx_pct = 0;
    int rx_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;
    int n_err = 0;
    int n_boxes = 0;
    int n_checked = 0;
    int n_settings = 0;

    function automatic box_out_t transform_box(box_in_t b);
        longint src_lo [3];
        longint src_hi [3];
        longint acc_lo [3];
        longint acc_hi [3];
        coord_t res [6];
        longint m;
        longint q;
        coef_t  c;
        bit     sat;
        box_out_t r;
        sat = 1'b0;
        src_lo[0] = b.box_min_x;
        src_lo[1] = b.box_min_y;
        src_lo[2] = b.box_min_z;
        src_hi[0] = b.box_max_x;
        src_hi[1] = b.box_max_y;
        src_hi[2] = b.box_max_z;
        for (int j = 0; j < 3; j++)
        begin
            acc_lo[j] = longint'(offset[j]) * 65536;
            acc_hi[j] = acc_lo[j];
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                c = mat_row[i][CoefW*j +: CoefW];
                m = c;
                if (m > 0)
                begin
                    acc_lo[j] += m * src_lo[i];
                    acc_hi[j] += m * src_hi[i];
                end
                else
                begin
                    acc_lo[j] += m * src_hi[i];
                    acc_hi[j] += m * src_lo[i];
                end
            end
        end
        for (int k = 0; k < 6; k++)
        begin
            q = ((k < 3) ? acc_lo[k] : acc_hi[k-3]) >>> FracW;
            if (q > 64'sd2147483647)
            begin
                q = 64'sd2147483647;
                sat = 1'b1;
            end
            if (q < -64'sd2147483648)
            begin
                q = -64'sd2147483648;
                sat = 1'b1;
            end
            res[k] = q[CoordW-1:0];
        end
        r.out_min_x = res[0];
        r.out_min_y = res[1];
        r.out_min_z = res[2];
        r.out_max_x = res[3];
        r.out_max_y = res[4];
        r.out_max_z = res[5];
        r.saturated = sat;
        return r;
    endfunction

    function automatic box_in_t mk_box(coord_t ax, coord_t ay, coord_t az,
                                       coord_t bx, coord_t by, coord_t bz);
        box_in_t b;
        b.box_min_x = ax;
        b.box_min_y = ay;
        b.box_min_z = az;
        b.box_max_x = bx;
        b.box_max_y = by;
        b.box_max_z = bz;
        return b;
    endfunction

    function automatic coord_t rand_coord();
        coord_t v;
        case ($urandom_range(0, 9))
            0: v = ($urandom_range(0, 1) != 0) ? CMAX : CMIN;
            1: v = coord_t'($urandom_range(0, 2)) - 1;
            2, 3, 4: v = coord_t'($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
            default: v = coord_t'($urandom);
        endcase
        return v;
    endfunction

    function automatic coef_t rand_coef();
        coef_t c;
        case ($urandom_range(0, 9))
            0: c = '0;
            1: c = KMAX;
            2: c = KMIN;
            3: c = ($urandom_range(0, 1) != 0) ? KONE : -KONE;
            4, 5: c = coef_t'($urandom_range(0, 20'h3FFFF)) - 20'sh20000;
            default: c = coef_t'($urandom);
        endcase
        return c;
    endfunction

    function automatic box_in_t rand_box();
        coord_t a [3];
        coord_t z [3];
        coord_t t;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = rand_coord();
            z[i] = rand_coord();
            // mostly well-ordered boxes, some left inverted
            if (a[i] > z[i] && $urandom_range(0, 4) != 0)
            begin
                t = a[i];
                a[i] = z[i];
                z[i] = t;
            end
        end
        return mk_box(a[0], a[1], a[2], z[0], z[1], z[2]);
    endfunction

    task automatic write_reg(input logic [IdxW-1:0] idx, input row_t data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_ROW_ONE:   mat_row[0] = data;
            REG_ROW_TWO:   mat_row[1] = data;
            REG_ROW_THREE: mat_row[2] = data;
            REG_SHIFT_X:   offset[0] = data[CoordW-1:0];
            REG_SHIFT_Y:   offset[1] = data[CoordW-1:0];
            REG_SHIFT_Z:   offset[2] = data[CoordW-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_matrix(input coef_t c00, input coef_t c01, input coef_t c02,
                                input coef_t c10, input coef_t c11, input coef_t c12,
                                input coef_t c20, input coef_t c21, input coef_t c22);
        write_reg(REG_ROW_ONE,   {c02, c01, c00});
        write_reg(REG_ROW_TWO,   {c12, c11, c10});
        write_reg(REG_ROW_THREE, {c22, c21, c20});
        n_settings++;
    endtask

    // upper bits of a shift write are junk on purpose
    task automatic write_offsets(input coord_t sx, input coord_t sy, input coord_t sz);
        write_reg(REG_SHIFT_X, {28'($urandom), sx});
        write_reg(REG_SHIFT_Y, {28'($urandom), sy});
        write_reg(REG_SHIFT_Z, {28'($urandom), sz});
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (box_q.size() != 0 || in_valid || want_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_pace(input int tx, input int rx);
        @(negedge clk);
        tx_pct = tx;
        rx_pct = rx;
    endtask

    task automatic check_field(input string name, input longint e, input longint a);
        if (e != a)
        begin
            $error("%s: expected %0d, got %0d", name, e, a);
            n_err++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                want_q.push_back(transform_box(in_data));
                n_boxes++;
            end
            if (!in_valid || !in_stall)
            begin
                if (box_q.size() != 0 && $urandom_range(0, 99) >= tx_pct)
                begin
                    in_data  <= box_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure, with one long hold-off
    always @(posedge clk)
    begin
        if (hold_cnt != 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < rx_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        box_out_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (want_q.size() == 0)
            begin
                $error("result beat with no pending box");
                n_err++;
            end
            else
            begin
                w = want_q.pop_front();
                n_checked++;
                check_field("out_min_x", w.out_min_x, out_data.out_min_x);
                check_field("out_min_y", w.out_min_y, out_data.out_min_y);
                check_field("out_min_z", w.out_min_z, out_data.out_min_z);
                check_field("out_max_x", w.out_max_x, out_data.out_max_x);
                check_field("out_max_y", w.out_max_y, out_data.out_max_y);
                check_field("out_max_z", w.out_max_z, out_data.out_max_z);
                check_field("saturated", w.saturated, out_data.saturated);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        mat_row[0] = RowOneRst;
        mat_row[1] = RowTwoRst;
        mat_row[2] = RowThreeRst;
        offset[0] = '0;
        offset[1] = '0;
        offset[2] = '0;
        n_settings = 1;
        tx_pct = 17;
        rx_pct = 56;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset identity
        set_pace(17, 56);
        box_q.push_back(mk_box(0, 0, 0, 0, 0, 0));
        box_q.push_back(mk_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        box_q.push_back(mk_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        box_q.push_back(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        box_q.push_back(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
        box_q.push_back(mk_box(-1, -1, -1, 1, 1, 1));
        box_q.push_back(mk_box(32'sh0001_8000, -32'sh0002_4000, 32'sh7, 3, 2, 1));
        wait_idle();

        // largest positive coefficients and offsets
        write_matrix(KMAX, KMAX, KMAX, KMAX, KMAX, KMAX, KMAX, KMAX, KMAX);
        write_offsets(CMAX, CMAX, CMAX);
        set_pace(17, 56);
        box_q.push_back(mk_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        box_q.push_back(mk_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        box_q.push_back(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        box_q.push_back(mk_box(0, 0, 0, 0, 0, 0));
        wait_idle();

        // most negative coefficients and offsets
        write_matrix(KMIN, KMIN, KMIN, KMIN, KMIN, KMIN, KMIN, KMIN, KMIN);
        write_offsets(CMIN, CMIN, CMIN);
        set_pace(17, 56);
        box_q.push_back(mk_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        box_q.push_back(mk_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        box_q.push_back(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        box_q.push_back(mk_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
        wait_idle();

        // zero matrix; spare indexes must be ignored
        write_matrix('0, '0, '0, '0, '0, '0, '0, '0, '0);
        write_offsets(32'sh0001_0000, -32'sh0000_8000, 0);
        write_reg(IDX_SPARE_A, row_t'({$urandom, $urandom}));
        write_reg(IDX_SPARE_B, row_t'({$urandom, $urandom}));
        set_pace(17, 56);
        box_q.push_back(mk_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        box_q.push_back(mk_box(CMAX, 5, -5, CMIN, -5, 5));
        box_q.push_back(mk_box(1, 2, 3, 4, 5, 6));
        wait_idle();

        // mixed signs, inverted boxes
        write_matrix(KONE, -KONE, '0, '0, KONE, -KONE, -KONE, '0, KONE);
        write_offsets(32'sh0000_0001, -1, 32'sh1234_5678);
        set_pace(17, 56);
        box_q.push_back(mk_box(32'sh0005_0000, -32'sh0003_0000, 7, -32'sh0005_0000,
                               32'sh0003_0000, -7));
        box_q.push_back(mk_box(-1, 0, 1, 1, 0, -1));
        box_q.push_back(mk_box(32'sh0000_0001, 32'sh0000_FFFF, -32'sh0000_FFFF,
                               32'sh0000_0002, 32'sh0001_0000, 0));
        box_q.push_back(mk_box(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN));
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_matrix(rand_coef(), rand_coef(), rand_coef(),
                         rand_coef(), rand_coef(), rand_coef(),
                         rand_coef(), rand_coef(), rand_coef());
            write_offsets(rand_coord(), rand_coord(), rand_coord());
            if ($urandom_range(0, 2) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? IDX_SPARE_A : IDX_SPARE_B,
                          row_t'({$urandom, $urandom}));
            if (p < 4)
                set_pace(17, 56);
            else if (p < 8)
                set_pace(56, 17);
            else
                set_pace(0, 0);
            if (p == 8)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_BOXES; k++)
                box_q.push_back(rand_box());
            wait_idle();
        end

        if (want_q.size() != 0)
        begin
            $error("%0d results never arrived", want_q.size());
            n_err++;
        end
        $display("Ran %0d boxes over %0d matrix settings, checked %0d results, %0d errors",
                 n_boxes, n_settings, n_checked, n_err);
        $display("Covered coefficient/offset extremes, saturation, inverted boxes, backpressure");
        if (n_err == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
